>>> hw/rtl/hghr_pkg.sv
// Package for the hierarchical group host range block.
// Holds field widths, register indexes and parameter defaults; depends on nothing.
package hghr_pkg;

	localparam int DEF_MAX_LEVELS     = 4;
	localparam int DEF_MAX_PROCESSORS = 1024;

	localparam int NUM_GROUP_REGS = 4;
	localparam int GRP_W          = 11;
	localparam int OWN_W          = 10;
	localparam int ID_W           = 16;
	localparam int DEPTH_W        = 3;
	localparam int BOUND_W        = 10;
	localparam int CFG_IDX_W      = 3;
	localparam int CFG_DATA_W     = 11;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_POLICY_CYCLIC   = 3'd0,
		REG_OWN_PROCESSOR   = 3'd1,
		REG_PROCESSOR_COUNT = 3'd2,
		REG_GROUPS_LEVEL0   = 3'd3,
		REG_GROUPS_LEVEL1   = 3'd4,
		REG_GROUPS_LEVEL2   = 3'd5,
		REG_GROUPS_LEVEL3   = 3'd6
	} reg_idx_t;

endpackage

>>> hw/rtl/hghr_if.sv
// Channel interfaces of the hierarchical group host range block.
// Depends on hghr_pkg for the field widths.
interface hghr_query_if import hghr_pkg::*; ();
	logic               valid;
	logic               ready;
	logic [DEPTH_W-1:0] depth;
	logic [ID_W-1:0]    level_id0;
	logic [ID_W-1:0]    level_id1;
	logic [ID_W-1:0]    level_id2;
	logic [ID_W-1:0]    level_id3;
	logic               counter_valid;
	logic [ID_W-1:0]    group_counter;

	modport source (output valid, depth, level_id0, level_id1, level_id2, level_id3,
		counter_valid, group_counter, input ready);
	modport sink (input valid, depth, level_id0, level_id1, level_id2, level_id3,
		counter_valid, group_counter, output ready);
endinterface

interface hghr_result_if import hghr_pkg::*; ();
	logic               valid;
	logic               ready;
	logic               allowed;
	logic [BOUND_W-1:0] lower_bound;
	logic [BOUND_W-1:0] upper_bound;
	logic               range_empty;

	modport source (output valid, allowed, lower_bound, upper_bound, range_empty,
		input ready);
	modport sink (input valid, allowed, lower_bound, upper_bound, range_empty,
		output ready);
endinterface

>>> hw/rtl/hierarchical_group_host_range.sv
// Top level of the hierarchical group host range block.
// Depends on hghr_pkg, hghr_if and hghr_div_chain.
//
// A query arrives on the query channel and one result leaves on the result
// channel; both use valid and ready, and a request moves when both are high.
// The configuration port writes one register per cycle with cfg_we high;
// the user must write it only while no query is in flight; the block does not enforce this.
// Each level runs two divisions through a chain of NW single-step cells
// (NW is 16 at the default size), then a multiply-add that moves the base
// and narrows the span; when the counter is used, a third division runs
// after the last level.
// One query is processed at a time.
// The result sits in an output register; a stalled receiver holds it there
// while the next query is already accepted and worked on, and that query
// waits for the register before it finishes.
// Reset returns the registers to their defaults and empties the datapath.
// Query ready is high whenever the block is between queries.
module hierarchical_group_host_range
	import hghr_pkg::*;
#(
	parameter int MAX_LEVELS     = DEF_MAX_LEVELS,
	parameter int MAX_PROCESSORS = DEF_MAX_PROCESSORS
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	hghr_query_if.sink            query,
	hghr_result_if.source         result
);
	localparam int SPAN_W = $clog2(MAX_PROCESSORS + 1);
	localparam int DW     = (GRP_W > SPAN_W) ? GRP_W : SPAN_W;
	localparam int NW     = (ID_W > SPAN_W) ? ID_W : SPAN_W;
	localparam int LVL_W  = $clog2(MAX_LEVELS + 1);
	localparam int CW     = ((SPAN_W > OWN_W) ? SPAN_W : OWN_W) + 2;

	typedef enum logic [2:0] {
		ST_IDLE, ST_LEVEL, ST_WSIZE, ST_WPICK, ST_MAC, ST_FIN, ST_WCNT, ST_DONE
	} state_t;

	logic              policy_q;
	logic [OWN_W-1:0]  own_q;
	logic [GRP_W-1:0]  pcount_q;
	logic [GRP_W-1:0]  groups_q [NUM_GROUP_REGS];

	state_t            state_q;
	logic [LVL_W-1:0]  lvl_q;
	logic [LVL_W-1:0]  depth_q;
	logic [ID_W-1:0]   id_q [NUM_GROUP_REGS];
	logic              cval_q;
	logic [ID_W-1:0]   cnt_q;
	logic [SPAN_W-1:0] span_q;
	logic [SPAN_W-1:0] base_q;
	logic [SPAN_W-1:0] size_q;
	logic [SPAN_W-1:0] prod_q;
	logic              res_allow_q;
	logic              res_empty_q;

	logic              div_valid;
	logic [NW-1:0]     div_num;
	logic [DW-1:0]     div_den;
	logic              dv_o;
	logic [NW-1:0]     dq_o;
	logic [DW-1:0]     dr_o;

	logic [GRP_W-1:0]  g_eff;
	logic [ID_W-1:0]   id_sel;
	logic [SPAN_W-1:0] span_init;
	logic [CW-1:0]     lower_w;
	logic [CW-1:0]     upper_w;
	logic [CW-1:0]     own_w;
	logic [DEPTH_W-1:0] depth_in;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			policy_q <= 1'b1;
			own_q    <= '0;
			pcount_q <= GRP_W'(1);
			for (int i = 0; i < NUM_GROUP_REGS; i++) groups_q[i] <= GRP_W'(1);
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_POLICY_CYCLIC:   policy_q <= cfg_data[0];
				REG_OWN_PROCESSOR:   own_q <= cfg_data[OWN_W-1:0];
				REG_PROCESSOR_COUNT: pcount_q <= cfg_data;
				REG_GROUPS_LEVEL0:   groups_q[0] <= cfg_data;
				REG_GROUPS_LEVEL1:   groups_q[1] <= cfg_data;
				REG_GROUPS_LEVEL2:   groups_q[2] <= cfg_data;
				REG_GROUPS_LEVEL3:   groups_q[3] <= cfg_data;
				default: ;
			endcase
		end
	end

	always_comb begin
		g_eff  = GRP_W'(1);
		id_sel = '0;
		for (int i = 0; i < NUM_GROUP_REGS; i++) begin
			if (32'(lvl_q) == i) begin
				g_eff  = (groups_q[i] == '0) ? GRP_W'(1) : groups_q[i];
				id_sel = id_q[i];
			end
		end
	end

	assign span_init = (32'(pcount_q) > MAX_PROCESSORS) ? SPAN_W'(MAX_PROCESSORS)
		: SPAN_W'(pcount_q);
	assign depth_in  = query.depth;
	assign lower_w   = CW'(base_q);
	assign upper_w   = CW'(base_q) + CW'(span_q) - CW'(1);
	assign own_w     = CW'(own_q);

	always_comb begin
		div_valid = 1'b0;
		div_num   = NW'(span_q);
		div_den   = DW'(g_eff);
		unique case (state_q)
			ST_LEVEL: div_valid = (lvl_q != depth_q);
			ST_WSIZE: begin
				div_valid = dv_o;
				div_num   = NW'(id_sel);
			end
			ST_FIN: begin
				div_valid = (span_q != '0) && policy_q && cval_q;
				div_num   = NW'(cnt_q);
				div_den   = DW'(span_q);
			end
			default: ;
		endcase
	end

	hghr_div_chain #(.NW(NW), .DW(DW)) u_chain (
		.clk(clk), .arst_n(arst_n),
		.valid_i(div_valid), .num_i(div_num), .den_i(div_den),
		.valid_o(dv_o), .quot_o(dq_o), .rem_o(dr_o)
	);

	assign query.ready = (state_q == ST_IDLE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			result.valid <= 1'b0;
			lvl_q        <= '0;
			depth_q      <= '0;
		end else begin
			if (state_q == ST_DONE && (!result.valid || result.ready))
				result.valid <= 1'b1;
			else if (result.ready)
				result.valid <= 1'b0;
			unique case (state_q)
				ST_IDLE: begin
					if (query.valid) begin
						depth_q <= (32'(depth_in) > MAX_LEVELS) ? LVL_W'(MAX_LEVELS)
							: LVL_W'(depth_in);
						lvl_q   <= '0;
						state_q <= ST_LEVEL;
					end
				end
				ST_LEVEL: state_q <= (lvl_q == depth_q) ? ST_FIN : ST_WSIZE;
				ST_WSIZE: if (dv_o) state_q <= ST_WPICK;
				ST_WPICK: if (dv_o) state_q <= ST_MAC;
				ST_MAC: begin
					lvl_q   <= lvl_q + LVL_W'(1);
					state_q <= ST_LEVEL;
				end
				ST_FIN: begin
					state_q <= (span_q != '0 && policy_q && cval_q) ? ST_WCNT : ST_DONE;
				end
				ST_WCNT: if (dv_o) state_q <= ST_DONE;
				ST_DONE: begin
					if (!result.valid || result.ready) state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			ST_IDLE: begin
				id_q[0] <= query.level_id0;
				id_q[1] <= query.level_id1;
				id_q[2] <= query.level_id2;
				id_q[3] <= query.level_id3;
				cval_q  <= query.counter_valid;
				cnt_q   <= query.group_counter;
				span_q  <= span_init;
				base_q  <= '0;
			end
			ST_WSIZE: if (dv_o) size_q <= SPAN_W'(dq_o);
			ST_WPICK: if (dv_o) prod_q <= SPAN_W'(dr_o * size_q);
			ST_MAC: begin
				base_q <= base_q + prod_q;
				span_q <= size_q;
			end
			ST_FIN: begin
				res_empty_q <= (span_q == '0);
				res_allow_q <= (span_q != '0) && policy_q && !cval_q
					&& (own_w >= lower_w) && (own_w <= upper_w);
			end
			ST_WCNT: if (dv_o) res_allow_q <= (lower_w + CW'(dr_o)) == own_w;
			ST_DONE: begin
				if (!result.valid || result.ready) begin
					result.allowed     <= res_allow_q;
					result.range_empty <= res_empty_q;
					result.lower_bound <= res_empty_q ? '0 : BOUND_W'(lower_w);
					result.upper_bound <= res_empty_q ? '0 : BOUND_W'(upper_w);
				end
			end
			default: ;
		endcase
	end
endmodule

>>> hw/rtl/hghr_cell.sv
// One restoring division step, registered, for the divider chain.
// Depends on nothing.
module hghr_cell #(
	parameter int NW = 16,
	parameter int DW = 11
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          valid_i,
	input  logic [DW-1:0] rem_i,
	input  logic [NW-1:0] num_i,
	input  logic [DW-1:0] den_i,
	output logic          valid_q,
	output logic [DW-1:0] rem_q,
	output logic [NW-1:0] num_q,
	output logic [DW-1:0] den_q
);
	logic [DW:0] trial;
	logic        ge;

	assign trial = {rem_i, num_i[NW-1]};
	assign ge    = trial >= {1'b0, den_i};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else begin
			valid_q <= valid_i;
		end
	end

	always_ff @(posedge clk) begin
		rem_q <= ge ? DW'(trial - {1'b0, den_i}) : DW'(trial);
		num_q <= {num_i[NW-2:0], ge};
		den_q <= den_i;
	end
endmodule

>>> hw/rtl/hghr_div_chain.sv
// Row of NW registered division cells; a request enters at one end and leaves at the other.
// Depends on hghr_cell.
module hghr_div_chain #(
	parameter int NW = 16,
	parameter int DW = 11
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          valid_i,
	input  logic [NW-1:0] num_i,
	input  logic [DW-1:0] den_i,
	output logic          valid_o,
	output logic [NW-1:0] quot_o,
	output logic [DW-1:0] rem_o
);
	logic          v [NW+1];
	logic [DW-1:0] r [NW+1];
	logic [NW-1:0] n [NW+1];
	logic [DW-1:0] d [NW+1];

	assign v[0] = valid_i;
	assign r[0] = '0;
	assign n[0] = num_i;
	assign d[0] = den_i;

	for (genvar i = 0; i < NW; i++) begin : g_cell
		hghr_cell #(.NW(NW), .DW(DW)) u_cell (
			.clk(clk), .arst_n(arst_n),
			.valid_i(v[i]), .rem_i(r[i]), .num_i(n[i]), .den_i(d[i]),
			.valid_q(v[i+1]), .rem_q(r[i+1]), .num_q(n[i+1]), .den_q(d[i+1])
		);
	end

	assign valid_o = v[NW];
	assign quot_o  = n[NW];
	assign rem_o   = r[NW];
endmodule
